### rtl/waveform_lod_fold_macros.svh
// Assertion macros shared by the checker of the waveform level-of-detail folder.
`ifndef WAVEFORM_LOD_FOLD_MACROS_SVH
`define WAVEFORM_LOD_FOLD_MACROS_SVH

`define WLF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("waveform_lod_fold check failed");

`define WLF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("waveform_lod_fold check failed");

`define WLF_ASSERT_RESET(lbl, cons) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error("waveform_lod_fold check failed");

`endif

### rtl/wlf_pkg.sv
// Shared types and constants of the waveform level-of-detail folder.
package wlf_pkg;

    localparam int MAX_RUN     = 16;
    localparam int AMP_W       = 8;
    localparam int COLOR_W     = 8;
    localparam int FLAGS_W     = 8;
    localparam int PROD_W      = COLOR_W + AMP_W;
    localparam int RUN_CNT_W   = $clog2(MAX_RUN + 1);
    localparam int WEIGHT_W    = $clog2(MAX_RUN * (1 << (AMP_W - 1)) + 1);
    localparam int SUM_W       = $clog2(MAX_RUN * (1 << (AMP_W - 1)) * ((1 << COLOR_W) - 1) + 1);
    localparam int DIV_W       = WEIGHT_W + COLOR_W;
    localparam int STEP_CNT_W  = $clog2(COLOR_W);
    localparam int NUM_COLORS  = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_AVAIL_MASK = 3'd0;
    localparam logic [FLAGS_W-1:0]    AVAIL_MASK_RESET = 8'h01;

    typedef struct packed {
        logic                       has_data;
        logic                       complete;
        logic signed [AMP_W-1:0]    run_min;
        logic signed [AMP_W-1:0]    run_max;
        logic [SUM_W-1:0]           red_sum;
        logic [SUM_W-1:0]           green_sum;
        logic [SUM_W-1:0]           blue_sum;
        logic [WEIGHT_W-1:0]        weight_sum;
        logic [FLAGS_W-1:0]         flags;
    } t_summary;

endpackage

### rtl/waveform_lod_fold.sv
// Top level of the waveform level-of-detail folder.
// Lines are taken one per clock cycle while the queue is not full and folded into a running
// min/max, flag AND and magnitude-weighted color sums. The line marked last ends a run; its
// summary goes into a two-entry queue, and a shared divider produces the three average colors
// one quotient bit per cycle; each run passes through the back end as queue pop, 8 division
// steps and output load before its result is shown. Short runs are limited by the divider,
// and full stays high while both queue entries wait. A result stays on the output ports
// until popped while the back end already works on the next run. The available_mask register
// is at byte address 0.
module waveform_lod_fold import wlf_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0]    pwdata,
    output logic [APB_DATA_W-1:0]    prdata,
    output logic                     pready,
    input  logic                     push,
    output logic                     full,
    input  logic                     i_line_present,
    input  logic signed [AMP_W-1:0]  i_line_min,
    input  logic signed [AMP_W-1:0]  i_line_max,
    input  logic [COLOR_W-1:0]       i_line_red,
    input  logic [COLOR_W-1:0]       i_line_green,
    input  logic [COLOR_W-1:0]       i_line_blue,
    input  logic [FLAGS_W-1:0]       i_line_flags,
    input  logic                     i_last_line,
    input  logic                     pop,
    output logic                     empty,
    output logic                     o_has_data,
    output logic                     o_complete,
    output logic signed [AMP_W-1:0]  o_out_min,
    output logic signed [AMP_W-1:0]  o_out_max,
    output logic [COLOR_W-1:0]       o_out_red,
    output logic [COLOR_W-1:0]       o_out_green,
    output logic [COLOR_W-1:0]       o_out_blue,
    output logic [FLAGS_W-1:0]       o_out_flags
);

    logic [FLAGS_W-1:0] r_avail_mask;
    logic               cfg_write;
    logic               in_accept;
    logic               front_push;
    t_summary           front_summary;
    logic               q_full;
    logic               q_empty;
    logic               q_pop;
    t_summary           q_head;

    always_comb begin
        pready    = 1'b1;
        cfg_write = psel && penable && pwrite && pready;
        prdata    = (paddr == ADDR_AVAIL_MASK) ? APB_DATA_W'(r_avail_mask) : '0;
        full      = q_full;
        in_accept = push && !q_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avail_mask <= AVAIL_MASK_RESET;
        end else if (cfg_write && (paddr == ADDR_AVAIL_MASK)) begin
            r_avail_mask <= pwdata[FLAGS_W-1:0];
        end
    end

    wlf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_avail_mask   (r_avail_mask),
        .i_accept       (in_accept),
        .i_line_present (i_line_present),
        .i_line_min     (i_line_min),
        .i_line_max     (i_line_max),
        .i_line_red     (i_line_red),
        .i_line_green   (i_line_green),
        .i_line_blue    (i_line_blue),
        .i_line_flags   (i_line_flags),
        .i_last_line    (i_last_line),
        .o_push         (front_push),
        .o_summary      (front_summary)
    );

    wlf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_summary),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    wlf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_has_data  (o_has_data),
        .o_complete  (o_complete),
        .o_out_min   (o_out_min),
        .o_out_max   (o_out_max),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_flags (o_out_flags)
    );

endmodule

### rtl/wlf_front.sv
// Front end: classifies each line and folds usable lines into the running sums.
module wlf_front import wlf_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [FLAGS_W-1:0]      i_avail_mask,
    input  logic                    i_accept,
    input  logic                    i_line_present,
    input  logic signed [AMP_W-1:0] i_line_min,
    input  logic signed [AMP_W-1:0] i_line_max,
    input  logic [COLOR_W-1:0]      i_line_red,
    input  logic [COLOR_W-1:0]      i_line_green,
    input  logic [COLOR_W-1:0]      i_line_blue,
    input  logic [FLAGS_W-1:0]      i_line_flags,
    input  logic                    i_last_line,
    output logic                    o_push,
    output t_summary                o_summary
);

    logic signed [AMP_W-1:0] r_run_min, n_run_min;
    logic signed [AMP_W-1:0] r_run_max, n_run_max;
    logic [SUM_W-1:0]        r_red_sum, n_red_sum;
    logic [SUM_W-1:0]        r_green_sum, n_green_sum;
    logic [SUM_W-1:0]        r_blue_sum, n_blue_sum;
    logic [WEIGHT_W-1:0]     r_weight_sum, n_weight_sum;
    logic [FLAGS_W-1:0]      r_flags_and, n_flags_and;
    logic                    r_seen_data, n_seen_data;
    logic                    r_all_complete, n_all_complete;
    logic [RUN_CNT_W-1:0]    r_run_count, n_run_count;

    logic                    over_run;
    logic                    usable;
    logic [AMP_W-1:0]        abs_min;
    logic [AMP_W-1:0]        abs_max;
    logic [AMP_W-1:0]        mag;
    logic [AMP_W-1:0]        weight;
    logic [PROD_W-1:0]       prod_red;
    logic [PROD_W-1:0]       prod_green;
    logic [PROD_W-1:0]       prod_blue;

    always_comb begin
        over_run = r_run_count >= RUN_CNT_W'(MAX_RUN);
        usable   = !over_run && i_line_present && ((i_line_flags & i_avail_mask) != '0);
        abs_min  = i_line_min[AMP_W-1] ? AMP_W'(-i_line_min) : AMP_W'(i_line_min);
        abs_max  = i_line_max[AMP_W-1] ? AMP_W'(-i_line_max) : AMP_W'(i_line_max);
        mag      = (abs_min > abs_max) ? abs_min : abs_max;
        weight   = (mag > AMP_W'(1)) ? mag : AMP_W'(1);
        prod_red   = PROD_W'(i_line_red) * PROD_W'(weight);
        prod_green = PROD_W'(i_line_green) * PROD_W'(weight);
        prod_blue  = PROD_W'(i_line_blue) * PROD_W'(weight);

        n_run_min      = r_run_min;
        n_run_max      = r_run_max;
        n_red_sum      = r_red_sum;
        n_green_sum    = r_green_sum;
        n_blue_sum     = r_blue_sum;
        n_weight_sum   = r_weight_sum;
        n_flags_and    = r_flags_and;
        n_seen_data    = r_seen_data;
        n_all_complete = r_all_complete;
        n_run_count    = r_run_count;

        if (!over_run) begin
            n_run_count = r_run_count + RUN_CNT_W'(1);
        end
        if (!usable) begin
            n_all_complete = 1'b0;
        end else begin
            if (!r_seen_data) begin
                n_run_min = i_line_min;
                n_run_max = i_line_max;
            end else begin
                if (i_line_min < r_run_min) begin
                    n_run_min = i_line_min;
                end
                if (i_line_max > r_run_max) begin
                    n_run_max = i_line_max;
                end
            end
            n_seen_data  = 1'b1;
            n_red_sum    = r_red_sum + SUM_W'(prod_red);
            n_green_sum  = r_green_sum + SUM_W'(prod_green);
            n_blue_sum   = r_blue_sum + SUM_W'(prod_blue);
            n_weight_sum = r_weight_sum + WEIGHT_W'(weight);
            n_flags_and  = r_flags_and & i_line_flags;
        end

        o_push               = i_accept && i_last_line;
        o_summary.has_data   = n_seen_data;
        o_summary.complete   = n_all_complete;
        o_summary.run_min    = n_seen_data ? n_run_min : '0;
        o_summary.run_max    = n_seen_data ? n_run_max : '0;
        o_summary.red_sum    = n_red_sum;
        o_summary.green_sum  = n_green_sum;
        o_summary.blue_sum   = n_blue_sum;
        o_summary.weight_sum = n_weight_sum;
        o_summary.flags      = n_seen_data ? n_flags_and : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_line)) begin
            r_run_min      <= '0;
            r_run_max      <= '0;
            r_red_sum      <= '0;
            r_green_sum    <= '0;
            r_blue_sum     <= '0;
            r_weight_sum   <= '0;
            r_flags_and    <= '1;
            r_seen_data    <= 1'b0;
            r_all_complete <= 1'b1;
            r_run_count    <= '0;
        end else if (i_accept) begin
            r_run_min      <= n_run_min;
            r_run_max      <= n_run_max;
            r_red_sum      <= n_red_sum;
            r_green_sum    <= n_green_sum;
            r_blue_sum     <= n_blue_sum;
            r_weight_sum   <= n_weight_sum;
            r_flags_and    <= n_flags_and;
            r_seen_data    <= n_seen_data;
            r_all_complete <= n_all_complete;
            r_run_count    <= n_run_count;
        end
    end

endmodule

### rtl/wlf_queue.sv
// Short queue of finished run summaries between the front end and the divider.
module wlf_queue import wlf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_summary i_data,
    input  logic     i_pop,
    output logic     o_full,
    output logic     o_empty,
    output t_summary o_head
);

    t_summary            r_entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                do_push;
    logic                do_pop;

    always_comb begin
        o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
        o_empty = r_count == '0;
        o_head  = r_entries[r_rd_ptr];
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entries[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

### rtl/wlf_back.sv
// Back end: divides the color sums by the weight sum, one quotient bit per cycle.
module wlf_back import wlf_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_empty,
    input  t_summary                 i_q_head,
    output logic                     o_q_pop,
    input  logic                     i_pop,
    output logic                     o_empty,
    output logic                     o_has_data,
    output logic                     o_complete,
    output logic signed [AMP_W-1:0]  o_out_min,
    output logic signed [AMP_W-1:0]  o_out_max,
    output logic [COLOR_W-1:0]       o_out_red,
    output logic [COLOR_W-1:0]       o_out_green,
    output logic [COLOR_W-1:0]       o_out_blue,
    output logic [FLAGS_W-1:0]       o_out_flags
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]              r_state;
    logic [STEP_CNT_W-1:0]   r_step;
    logic [DIV_W-1:0]        r_rem [NUM_COLORS];
    logic [DIV_W-1:0]        n_rem [NUM_COLORS];
    logic [COLOR_W-1:0]      r_quo [NUM_COLORS];
    logic [COLOR_W-1:0]      n_quo [NUM_COLORS];
    logic [DIV_W-1:0]        r_dvs;
    logic                    r_has_data;
    logic                    r_complete;
    logic signed [AMP_W-1:0] r_min;
    logic signed [AMP_W-1:0] r_max;
    logic [FLAGS_W-1:0]      r_flags;
    logic                    r_out_valid;
    logic                    pop_ok;
    logic                    out_load;

    always_comb begin
        for (int i = 0; i < NUM_COLORS; i++) begin
            if (r_rem[i] >= r_dvs) begin
                n_rem[i] = r_rem[i] - r_dvs;
                n_quo[i] = {r_quo[i][COLOR_W-2:0], 1'b1};
            end else begin
                n_rem[i] = r_rem[i];
                n_quo[i] = {r_quo[i][COLOR_W-2:0], 1'b0};
            end
        end
        pop_ok   = i_pop && r_out_valid;
        out_load = (r_state == ST_WAIT) && (!r_out_valid || pop_ok);
        o_q_pop  = (r_state == ST_IDLE) && !i_q_empty;
        o_empty  = !r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_step == '0) begin
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (pop_ok) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rem[0]   <= DIV_W'(i_q_head.red_sum);
            r_rem[1]   <= DIV_W'(i_q_head.green_sum);
            r_rem[2]   <= DIV_W'(i_q_head.blue_sum);
            r_quo[0]   <= '0;
            r_quo[1]   <= '0;
            r_quo[2]   <= '0;
            r_dvs      <= DIV_W'(i_q_head.weight_sum) << (COLOR_W - 1);
            r_step     <= STEP_CNT_W'(COLOR_W - 1);
            r_has_data <= i_q_head.has_data;
            r_complete <= i_q_head.complete;
            r_min      <= i_q_head.run_min;
            r_max      <= i_q_head.run_max;
            r_flags    <= i_q_head.flags;
        end else if (r_state == ST_DIV) begin
            for (int i = 0; i < NUM_COLORS; i++) begin
                r_rem[i] <= n_rem[i];
                r_quo[i] <= n_quo[i];
            end
            r_dvs  <= r_dvs >> 1;
            r_step <= r_step - STEP_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_has_data  <= r_has_data;
            o_complete  <= r_complete;
            o_out_min   <= r_min;
            o_out_max   <= r_max;
            o_out_red   <= r_has_data ? r_quo[0] : '0;
            o_out_green <= r_has_data ? r_quo[1] : '0;
            o_out_blue  <= r_has_data ? r_quo[2] : '0;
            o_out_flags <= r_flags;
        end
    end

endmodule

### rtl/wlf_checker.sv
// Port-level checker of the waveform level-of-detail folder and its binding.
`include "waveform_lod_fold_macros.svh"

module wlf_checker import wlf_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     pop,
    input logic                     empty,
    input logic                     o_has_data,
    input logic                     o_complete,
    input logic signed [AMP_W-1:0]  o_out_min,
    input logic signed [AMP_W-1:0]  o_out_max,
    input logic [COLOR_W-1:0]       o_out_red,
    input logic [COLOR_W-1:0]       o_out_green,
    input logic [COLOR_W-1:0]       o_out_blue,
    input logic [FLAGS_W-1:0]       o_out_flags
);

    // No result may be pending right after reset.
    `WLF_ASSERT_RESET(a_empty_after_reset, empty)

    // A run without usable lines has had a missing or unavailable line.
    `WLF_ASSERT_SAME(a_no_data_incomplete, !empty && !o_has_data, !o_complete)

    // A run without usable lines reports all numeric fields as zero.
    `WLF_ASSERT_SAME(a_no_data_zero, !empty && !o_has_data,
        o_out_min == '0 && o_out_max == '0 && o_out_red == '0 &&
        o_out_green == '0 && o_out_blue == '0 && o_out_flags == '0)

    // A result that is not taken stays unchanged.
    `WLF_ASSERT_NEXT(a_result_holds, !empty && !pop,
        !empty && $stable(o_out_red) && $stable(o_out_min) && $stable(o_out_flags))

endmodule

bind waveform_lod_fold wlf_checker u_wlf_checker (.*);
